[hw/rtl/lav_pkg.sv]
// Shared constants, register codes and rounding helpers for the look-at view basis unit.
package lav_pkg;

    localparam int FRAC_BITS_DEF = 16;

    localparam int IN_W    = 24;
    localparam int AXIS_W  = 18;
    localparam int SHIFT_W = 26;
    localparam int REG_W   = 3;

    localparam int SQ_W        = 30;
    localparam int SQ2_W       = 2 * SQ_W;
    localparam int SUM_W       = 62;
    localparam int ROOT_W      = 31;
    localparam int H_W         = 5;
    localparam int ISQRT_STEPS = 31;

    localparam logic signed [63:0] SHIFT_LIM = 64'sd16777216;

    localparam logic [REG_W-1:0] REG_TARGET_X = 3'd0;
    localparam logic [REG_W-1:0] REG_TARGET_Y = 3'd1;
    localparam logic [REG_W-1:0] REG_TARGET_Z = 3'd2;
    localparam logic [REG_W-1:0] REG_UPVEC_X  = 3'd3;
    localparam logic [REG_W-1:0] REG_UPVEC_Y  = 3'd4;
    localparam logic [REG_W-1:0] REG_UPVEC_Z  = 3'd5;

    localparam logic signed [IN_W-1:0] TARGET_X_RST = 24'sd1311;
    localparam logic signed [IN_W-1:0] TARGET_Y_RST = 24'sd0;
    localparam logic signed [IN_W-1:0] TARGET_Z_RST = 24'sd0;
    localparam logic signed [IN_W-1:0] UPVEC_X_RST  = 24'sd0;
    localparam logic signed [IN_W-1:0] UPVEC_Y_RST  = 24'sd65536;
    localparam logic signed [IN_W-1:0] UPVEC_Z_RST  = 24'sd0;

    function automatic int norm_lat(input int frac);
        return 41 + frac;
    endfunction

    function automatic logic signed [63:0] rshf(input logic signed [63:0] x, input int frac);
        logic [63:0] m;
        logic [63:0] q;
        m = (x < 0) ? 64'(-x) : 64'(x);
        q = (m + (64'd1 << (frac - 1))) >> frac;
        return (x < 0) ? -$signed(q) : $signed(q);
    endfunction

    function automatic logic signed [63:0] clampi(input logic signed [63:0] x,
                                                  input logic signed [63:0] lim);
        if (x > lim) begin
            return lim;
        end
        if (x < -lim) begin
            return -lim;
        end
        return x;
    endfunction

endpackage

[hw/rtl/lav_delay.sv]
// Enabled delay line for side data that travels next to the arithmetic stages.
module lav_delay import lav_pkg::*; #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             aclk,
    input  logic             en,
    input  logic [WIDTH-1:0] data_in,
    output logic [WIDTH-1:0] data_out
);

    logic [WIDTH-1:0] tap_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (en) begin
            tap_reg[0] <= data_in;
            for (int i = 1; i < DEPTH; i++) begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign data_out = tap_reg[DEPTH-1];

endmodule

[hw/rtl/lav_isqrt.sv]
// Pipelined integer square root, one result bit per stage.
module lav_isqrt import lav_pkg::*; (
    input  logic              aclk,
    input  logic              en,
    input  logic [SUM_W-1:0]  rad,
    output logic [ROOT_W-1:0] root
);

    localparam int XW = SUM_W + 1;

    logic [XW-1:0] x_reg [ISQRT_STEPS];
    logic [XW-1:0] r_reg [ISQRT_STEPS];

    for (genvar j = 0; j < ISQRT_STEPS; j++) begin : g_step
        localparam logic [XW-1:0] BIT = XW'(1) << (2 * (ISQRT_STEPS - 1 - j));
        logic [XW-1:0] x_in;
        logic [XW-1:0] r_in;
        logic [XW-1:0] x_next;
        logic [XW-1:0] r_next;

        if (j == 0) begin : g_first
            assign x_in = XW'(rad);
            assign r_in = '0;
        end else begin : g_rest
            assign x_in = x_reg[j-1];
            assign r_in = r_reg[j-1];
        end

        always_comb begin
            if (x_in >= r_in + BIT) begin
                x_next = x_in - (r_in + BIT);
                r_next = (r_in >> 1) + BIT;
            end else begin
                x_next = x_in;
                r_next = r_in >> 1;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                x_reg[j] <= x_next;
                r_reg[j] <= r_next;
            end
        end
    end

    assign root = ROOT_W'(r_reg[ISQRT_STEPS-1]);

endmodule

[hw/rtl/lav_div.sv]
// Pipelined restoring divider: rounded unit component, one quotient bit per stage.
module lav_div import lav_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 en,
    input  logic [SQ_W-1:0]      mag,
    input  logic [H_W-1:0]       hsh,
    input  logic [ROOT_W-1:0]    root,
    output logic [FRAC_BITS:0]   quot
);

    localparam int Q  = FRAC_BITS + 1;
    localparam int NW = ROOT_W + FRAC_BITS + 1;

    logic [NW-1:0]     rem0_reg;
    logic [ROOT_W-1:0] div0_reg;
    logic [NW-1:0]     rem_reg [Q];
    logic [ROOT_W-1:0] div_reg [Q];
    logic [Q-1:0]      q_reg   [Q];

    always_ff @(posedge aclk) begin
        if (en) begin
            rem0_reg <= (NW'(mag) << (FRAC_BITS + int'(hsh))) + NW'(root >> 1);
            div0_reg <= root;
        end
    end

    for (genvar j = 0; j < Q; j++) begin : g_bit
        logic [NW-1:0]     rem_in;
        logic [ROOT_W-1:0] div_in;
        logic [Q-1:0]      q_in;
        logic [NW-1:0]     dsh;
        logic [NW-1:0]     rem_next;
        logic [Q-1:0]      q_next;

        if (j == 0) begin : g_first
            assign rem_in = rem0_reg;
            assign div_in = div0_reg;
            assign q_in   = '0;
        end else begin : g_rest
            assign rem_in = rem_reg[j-1];
            assign div_in = div_reg[j-1];
            assign q_in   = q_reg[j-1];
        end

        assign dsh = NW'(div_in) << (Q - 1 - j);

        always_comb begin
            if (rem_in >= dsh) begin
                rem_next = rem_in - dsh;
                q_next   = (q_in << 1) | Q'(1);
            end else begin
                rem_next = rem_in;
                q_next   = q_in << 1;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[j] <= rem_next;
                div_reg[j] <= div_in;
                q_reg[j]   <= q_next;
            end
        end
    end

    assign quot = q_reg[Q-1];

endmodule

[hw/rtl/lav_norm.sv]
// Vector normalizer: pre-shift, sum of squares, square root and three dividers.
module lav_norm import lav_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int IN_BITS   = 25
) (
    input  logic                        aclk,
    input  logic                        en,
    input  logic signed [IN_BITS-1:0]   vec  [3],
    output logic signed [FRAC_BITS+1:0] unit [3],
    output logic                        zero
);

    localparam int KW  = $clog2(IN_BITS + 1);
    localparam int UW  = FRAC_BITS + 2;
    localparam int ISQ = ISQRT_STEPS;
    localparam int DVL = FRAC_BITS + 2;

    logic [IN_BITS-1:0] mag1_reg [3];
    logic [2:0]         sgn1_reg;
    logic [IN_BITS-1:0] mag2_reg [3];
    logic [2:0]         sgn2_reg;
    logic [KW-1:0]      k2_reg;
    logic [SQ_W-1:0]    sm3_reg  [3];
    logic [2:0]         sgn3_reg;
    logic [SQ2_W-1:0]   sq4_reg  [3];
    logic [SQ_W-1:0]    sm4_reg  [3];
    logic [2:0]         sgn4_reg;
    logic [SUM_W-1:0]   sum5_reg;
    logic [SQ_W-1:0]    sm5_reg  [3];
    logic [2:0]         sgn5_reg;
    logic               zero5_reg;
    logic [SUM_W-1:0]   sum6_reg;
    logic [SQ_W-1:0]    sm6_reg  [3];
    logic [2:0]         sgn6_reg;
    logic               zero6_reg;
    logic [H_W-1:0]     h6_reg;
    logic [SUM_W-1:0]   x7_reg;
    logic [SQ_W-1:0]    sm7_reg  [3];
    logic [2:0]         sgn7_reg;
    logic               zero7_reg;
    logic [H_W-1:0]     h7_reg;

    logic [IN_BITS-1:0] orv;
    logic [KW-1:0]      k_next;
    logic [H_W-1:0]     h_next;
    int                 bl;
    int                 msb;

    logic [ROOT_W-1:0]  root;
    logic [3*SQ_W+H_W-1:0] side_d;
    logic [3:0]         sz_d;
    logic [FRAC_BITS:0] quot [3];
    logic signed [UW-1:0] unit_reg [3];
    logic               zero_reg;

    always_comb begin
        orv = mag1_reg[0] | mag1_reg[1] | mag1_reg[2];
        bl  = 0;
        for (int i = 0; i < IN_BITS; i++) begin
            if (orv[i]) begin
                bl = i + 1;
            end
        end
        k_next = (bl > SQ_W) ? KW'(bl - SQ_W) : '0;
    end

    always_comb begin
        msb = 0;
        for (int i = 0; i < SUM_W; i++) begin
            if (sum5_reg[i]) begin
                msb = i;
            end
        end
        h_next = H_W'((SUM_W - 1 - msb) >> 1);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                mag1_reg[i] <= vec[i][IN_BITS-1] ? IN_BITS'(-vec[i]) : IN_BITS'(vec[i]);
                sgn1_reg[i] <= vec[i][IN_BITS-1];
                mag2_reg[i] <= mag1_reg[i];
                sm3_reg[i]  <= SQ_W'(mag2_reg[i] >> k2_reg);
                sq4_reg[i]  <= SQ2_W'(sm3_reg[i]) * SQ2_W'(sm3_reg[i]);
                sm4_reg[i]  <= sm3_reg[i];
                sm5_reg[i]  <= sm4_reg[i];
                sm6_reg[i]  <= sm5_reg[i];
                sm7_reg[i]  <= sm6_reg[i];
            end
            sgn2_reg  <= sgn1_reg;
            k2_reg    <= k_next;
            sgn3_reg  <= sgn2_reg;
            sgn4_reg  <= sgn3_reg;
            sum5_reg  <= SUM_W'(sq4_reg[0]) + SUM_W'(sq4_reg[1]) + SUM_W'(sq4_reg[2]);
            zero5_reg <= (sq4_reg[0] == '0) && (sq4_reg[1] == '0) && (sq4_reg[2] == '0);
            sgn5_reg  <= sgn4_reg;
            sum6_reg  <= sum5_reg;
            zero6_reg <= zero5_reg;
            sgn6_reg  <= sgn5_reg;
            h6_reg    <= h_next;
            x7_reg    <= sum6_reg << (2 * int'(h6_reg));
            zero7_reg <= zero6_reg;
            sgn7_reg  <= sgn6_reg;
            h7_reg    <= h6_reg;
        end
    end

    lav_isqrt u_isqrt (
        .aclk (aclk),
        .en   (en),
        .rad  (x7_reg),
        .root (root)
    );

    lav_delay #(.WIDTH(3 * SQ_W + H_W), .DEPTH(ISQ)) u_side (
        .aclk     (aclk),
        .en       (en),
        .data_in  ({sm7_reg[2], sm7_reg[1], sm7_reg[0], h7_reg}),
        .data_out (side_d)
    );

    lav_delay #(.WIDTH(4), .DEPTH(ISQ + DVL)) u_sz (
        .aclk     (aclk),
        .en       (en),
        .data_in  ({zero7_reg, sgn7_reg}),
        .data_out (sz_d)
    );

    for (genvar i = 0; i < 3; i++) begin : g_div
        lav_div #(.FRAC_BITS(FRAC_BITS)) u_div (
            .aclk (aclk),
            .en   (en),
            .mag  (side_d[H_W + i*SQ_W +: SQ_W]),
            .hsh  (side_d[H_W-1:0]),
            .root (root),
            .quot (quot[i])
        );
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                if (sz_d[3]) begin
                    unit_reg[i] <= '0;
                end else if (sz_d[i]) begin
                    unit_reg[i] <= -$signed(UW'(quot[i]));
                end else begin
                    unit_reg[i] <= $signed(UW'(quot[i]));
                end
            end
            zero_reg <= sz_d[3];
        end
    end

    assign unit = unit_reg;
    assign zero = zero_reg;

endmodule

[hw/rtl/lav_cross.sv]
// Two-stage cross product: six products, then three differences.
module lav_cross import lav_pkg::*; #(
    parameter int A_W = 24,
    parameter int B_W = 18
) (
    input  logic                        aclk,
    input  logic                        en,
    input  logic signed [A_W-1:0]       a [3],
    input  logic signed [B_W-1:0]       b [3],
    output logic signed [A_W+B_W:0]     c [3]
);

    localparam int P_W = A_W + B_W;
    localparam int C_W = P_W + 1;

    logic signed [P_W-1:0] p_reg [6];
    logic signed [C_W-1:0] c_reg [3];

    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg[0] <= P_W'(a[1]) * P_W'(b[2]);
            p_reg[1] <= P_W'(a[2]) * P_W'(b[1]);
            p_reg[2] <= P_W'(a[2]) * P_W'(b[0]);
            p_reg[3] <= P_W'(a[0]) * P_W'(b[2]);
            p_reg[4] <= P_W'(a[0]) * P_W'(b[1]);
            p_reg[5] <= P_W'(a[1]) * P_W'(b[0]);
            for (int i = 0; i < 3; i++) begin
                c_reg[i] <= C_W'(p_reg[2*i]) - C_W'(p_reg[2*i+1]);
            end
        end
    end

    assign c = c_reg;

endmodule

[hw/rtl/lav_dot.sv]
// Two-stage dot product: three products, then their sum.
module lav_dot import lav_pkg::*; #(
    parameter int A_W = 18,
    parameter int B_W = 24
) (
    input  logic                        aclk,
    input  logic                        en,
    input  logic signed [A_W-1:0]       a [3],
    input  logic signed [B_W-1:0]       b [3],
    output logic signed [A_W+B_W+1:0]   dot
);

    localparam int P_W = A_W + B_W;
    localparam int D_W = P_W + 2;

    logic signed [P_W-1:0] p_reg [3];
    logic signed [D_W-1:0] dot_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                p_reg[i] <= P_W'(a[i]) * P_W'(b[i]);
            end
            dot_reg <= D_W'(p_reg[0]) + D_W'(p_reg[1]) + D_W'(p_reg[2]);
        end
    end

    assign dot = dot_reg;

endmodule

[hw/rtl/look_at_view_matrix_unit.sv]
// Look-at view basis unit top level: config registers, basis pipeline and output register.
// Throughput: one eye position per cycle unless the output stalls; depth is set by the two
// square root pipelines (31 stages each) and the two banks of bit-per-stage dividers
// (FRAC_BITS+2 stages each). Eye and register inputs are Q8.16 at the default FRAC_BITS of 16.
// Reset: synchronous, active low; clears all valid bits and loads the register defaults.
module look_at_view_matrix_unit import lav_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wen,
    input  logic [REG_W-1:0]          cfg_index,
    input  logic [IN_W-1:0]           cfg_wdata,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic signed [IN_W-1:0]    s_eye_x,
    input  logic signed [IN_W-1:0]    s_eye_y,
    input  logic signed [IN_W-1:0]    s_eye_z,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [AXIS_W-1:0]  m_right_x,
    output logic signed [AXIS_W-1:0]  m_right_y,
    output logic signed [AXIS_W-1:0]  m_right_z,
    output logic signed [AXIS_W-1:0]  m_upward_x,
    output logic signed [AXIS_W-1:0]  m_upward_y,
    output logic signed [AXIS_W-1:0]  m_upward_z,
    output logic signed [AXIS_W-1:0]  m_backward_x,
    output logic signed [AXIS_W-1:0]  m_backward_y,
    output logic signed [AXIS_W-1:0]  m_backward_z,
    output logic signed [SHIFT_W-1:0] m_shift_u,
    output logic signed [SHIFT_W-1:0] m_shift_v,
    output logic signed [SHIFT_W-1:0] m_shift_n
);

    localparam int UW  = FRAC_BITS + 2;
    localparam int DW  = IN_W + 1;
    localparam int CW  = IN_W + UW + 1;
    localparam int VRW = 2 * UW + 1;
    localparam int EDW = UW + IN_W + 2;
    localparam int LN  = norm_lat(FRAC_BITS);
    localparam int TOT = 2 * LN + 9;
    localparam logic signed [63:0] ONE = 64'sd1 <<< FRAC_BITS;

    logic signed [IN_W-1:0] target_reg [3];
    logic signed [IN_W-1:0] upvec_reg  [3];

    logic [TOT-1:0] vld_reg;
    logic           en;
    logic           m_valid_reg;

    logic signed [IN_W-1:0] eye_in [3];
    logic signed [IN_W-1:0] ea_reg [3];
    logic signed [DW-1:0]   da_reg [3];

    logic signed [UW-1:0]  n_unit [3];
    logic                  nz;
    logic                  nz_d;
    logic signed [CW-1:0]  c_vec  [3];
    logic signed [UW-1:0]  u_unit [3];
    logic                  uz;

    logic [3*IN_W-1:0]     e_u_pk;
    logic [3*IN_W-1:0]     e_v_pk;
    logic [3*UW-1:0]       n_u_pk;
    logic [3*UW-1:0]       n_f_pk;
    logic [3*UW-1:0]       u_f_pk;
    logic [3*UW-1:0]       v_f_pk;
    logic [2*SHIFT_W-1:0]  s_f_pk;
    logic                  z_f;

    logic signed [IN_W-1:0] e_u [3];
    logic signed [IN_W-1:0] e_v [3];
    logic signed [UW-1:0]   n_u [3];
    logic signed [VRW-1:0]  v_raw [3];
    logic signed [EDW-1:0]  dot_u;
    logic signed [EDW-1:0]  dot_n;
    logic signed [EDW-1:0]  dot_v;

    logic signed [UW-1:0]      v_reg [3];
    logic signed [SHIFT_W-1:0] su_reg;
    logic signed [SHIFT_W-1:0] sn_reg;

    logic signed [AXIS_W-1:0]  fr_reg [3];
    logic signed [AXIS_W-1:0]  fv_reg [3];
    logic signed [AXIS_W-1:0]  fn_reg [3];
    logic signed [SHIFT_W-1:0] fsu_reg;
    logic signed [SHIFT_W-1:0] fsv_reg;
    logic signed [SHIFT_W-1:0] fsn_reg;

    logic signed [AXIS_W-1:0]  or_reg [3];
    logic signed [AXIS_W-1:0]  ov_reg [3];
    logic signed [AXIS_W-1:0]  on_reg [3];
    logic signed [SHIFT_W-1:0] osu_reg;
    logic signed [SHIFT_W-1:0] osv_reg;
    logic signed [SHIFT_W-1:0] osn_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg[0] <= TARGET_X_RST;
            target_reg[1] <= TARGET_Y_RST;
            target_reg[2] <= TARGET_Z_RST;
            upvec_reg[0]  <= UPVEC_X_RST;
            upvec_reg[1]  <= UPVEC_Y_RST;
            upvec_reg[2]  <= UPVEC_Z_RST;
        end else if (cfg_wen) begin
            unique case (cfg_index)
                REG_TARGET_X: target_reg[0] <= cfg_wdata;
                REG_TARGET_Y: target_reg[1] <= cfg_wdata;
                REG_TARGET_Z: target_reg[2] <= cfg_wdata;
                REG_UPVEC_X:  upvec_reg[0]  <= cfg_wdata;
                REG_UPVEC_Y:  upvec_reg[1]  <= cfg_wdata;
                REG_UPVEC_Z:  upvec_reg[2]  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // advance whenever the last stage is empty or the output register can take it
    assign en      = !vld_reg[TOT-1] || !m_valid_reg || m_ready;
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[TOT-2:0], s_valid};
        end
    end

    assign eye_in[0] = s_eye_x;
    assign eye_in[1] = s_eye_y;
    assign eye_in[2] = s_eye_z;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                ea_reg[i] <= eye_in[i];
                da_reg[i] <= DW'(eye_in[i]) - DW'(target_reg[i]);
            end
        end
    end

    lav_norm #(.FRAC_BITS(FRAC_BITS), .IN_BITS(DW)) u_norm_n (
        .aclk (aclk),
        .en   (en),
        .vec  (da_reg),
        .unit (n_unit),
        .zero (nz)
    );

    lav_delay #(.WIDTH(1), .DEPTH(LN + 2)) u_dly_nz (
        .aclk     (aclk),
        .en       (en),
        .data_in  (nz),
        .data_out (nz_d)
    );

    lav_cross #(.A_W(IN_W), .B_W(UW)) u_cross_c (
        .aclk (aclk),
        .en   (en),
        .a    (upvec_reg),
        .b    (n_unit),
        .c    (c_vec)
    );

    lav_norm #(.FRAC_BITS(FRAC_BITS), .IN_BITS(CW)) u_norm_u (
        .aclk (aclk),
        .en   (en),
        .vec  (c_vec),
        .unit (u_unit),
        .zero (uz)
    );

    lav_delay #(.WIDTH(3 * IN_W), .DEPTH(2 * LN + 2)) u_dly_eu (
        .aclk     (aclk),
        .en       (en),
        .data_in  ({ea_reg[2], ea_reg[1], ea_reg[0]}),
        .data_out (e_u_pk)
    );

    lav_delay #(.WIDTH(3 * UW), .DEPTH(LN + 2)) u_dly_nu (
        .aclk     (aclk),
        .en       (en),
        .data_in  ({n_unit[2], n_unit[1], n_unit[0]}),
        .data_out (n_u_pk)
    );

    for (genvar i = 0; i < 3; i++) begin : g_unpack
        assign e_u[i] = e_u_pk[i*IN_W +: IN_W];
        assign e_v[i] = e_v_pk[i*IN_W +: IN_W];
        assign n_u[i] = n_u_pk[i*UW +: UW];
    end

    lav_cross #(.A_W(UW), .B_W(UW)) u_cross_v (
        .aclk (aclk),
        .en   (en),
        .a    (n_u),
        .b    (u_unit),
        .c    (v_raw)
    );

    lav_dot #(.A_W(UW), .B_W(IN_W)) u_dot_u (
        .aclk (aclk),
        .en   (en),
        .a    (u_unit),
        .b    (e_u),
        .dot  (dot_u)
    );

    lav_dot #(.A_W(UW), .B_W(IN_W)) u_dot_n (
        .aclk (aclk),
        .en   (en),
        .a    (n_u),
        .b    (e_u),
        .dot  (dot_n)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                v_reg[i] <= UW'(clampi(rshf(64'(v_raw[i]), FRAC_BITS), ONE));
            end
            su_reg <= SHIFT_W'(clampi(-rshf(64'(dot_u), FRAC_BITS), SHIFT_LIM));
            sn_reg <= SHIFT_W'(clampi(-rshf(64'(dot_n), FRAC_BITS), SHIFT_LIM));
        end
    end

    lav_delay #(.WIDTH(3 * IN_W), .DEPTH(3)) u_dly_ev (
        .aclk     (aclk),
        .en       (en),
        .data_in  (e_u_pk),
        .data_out (e_v_pk)
    );

    lav_dot #(.A_W(UW), .B_W(IN_W)) u_dot_v (
        .aclk (aclk),
        .en   (en),
        .a    (v_reg),
        .b    (e_v),
        .dot  (dot_v)
    );

    lav_delay #(.WIDTH(3 * UW), .DEPTH(5)) u_dly_uf (
        .aclk     (aclk),
        .en       (en),
        .data_in  ({u_unit[2], u_unit[1], u_unit[0]}),
        .data_out (u_f_pk)
    );

    lav_delay #(.WIDTH(3 * UW), .DEPTH(5)) u_dly_nf (
        .aclk     (aclk),
        .en       (en),
        .data_in  (n_u_pk),
        .data_out (n_f_pk)
    );

    lav_delay #(.WIDTH(1), .DEPTH(5)) u_dly_zf (
        .aclk     (aclk),
        .en       (en),
        .data_in  (uz || nz_d),
        .data_out (z_f)
    );

    lav_delay #(.WIDTH(3 * UW), .DEPTH(2)) u_dly_vf (
        .aclk     (aclk),
        .en       (en),
        .data_in  ({v_reg[2], v_reg[1], v_reg[0]}),
        .data_out (v_f_pk)
    );

    lav_delay #(.WIDTH(2 * SHIFT_W), .DEPTH(2)) u_dly_sf (
        .aclk     (aclk),
        .en       (en),
        .data_in  ({sn_reg, su_reg}),
        .data_out (s_f_pk)
    );

    // drop everything to zero when either normalization had nothing to work with
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                fr_reg[i] <= z_f ? '0 : AXIS_W'($signed(u_f_pk[i*UW +: UW]));
                fv_reg[i] <= z_f ? '0 : AXIS_W'($signed(v_f_pk[i*UW +: UW]));
                fn_reg[i] <= z_f ? '0 : AXIS_W'($signed(n_f_pk[i*UW +: UW]));
            end
            fsu_reg <= z_f ? '0 : $signed(s_f_pk[SHIFT_W-1:0]);
            fsn_reg <= z_f ? '0 : $signed(s_f_pk[2*SHIFT_W-1:SHIFT_W]);
            fsv_reg <= z_f ? '0 :
                SHIFT_W'(clampi(-rshf(64'(dot_v), FRAC_BITS), SHIFT_LIM));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (!m_valid_reg || m_ready) begin
            m_valid_reg <= vld_reg[TOT-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!m_valid_reg || m_ready) begin
            or_reg  <= fr_reg;
            ov_reg  <= fv_reg;
            on_reg  <= fn_reg;
            osu_reg <= fsu_reg;
            osv_reg <= fsv_reg;
            osn_reg <= fsn_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_right_x    = or_reg[0];
    assign m_right_y    = or_reg[1];
    assign m_right_z    = or_reg[2];
    assign m_upward_x   = ov_reg[0];
    assign m_upward_y   = ov_reg[1];
    assign m_upward_z   = ov_reg[2];
    assign m_backward_x = on_reg[0];
    assign m_backward_y = on_reg[1];
    assign m_backward_z = on_reg[2];
    assign m_shift_u    = osu_reg;
    assign m_shift_v    = osv_reg;
    assign m_shift_n    = osn_reg;

endmodule

[test/tb_top.sv]
// Self-checking testbench for the look-at view basis unit, with a bit-true basis predictor.
module tb_top;
    import lav_pkg::*;

    localparam int FRAC        = FRAC_BITS_DEF;
    localparam int IDLE_LIMIT  = 4000;
    localparam int HOLD_CYCLES = 600;
    localparam int DRAIN_WAIT  = 2 * FRAC + 100;
    localparam int PHASE_ITEMS = 160;
    localparam logic [REG_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [REG_W-1:0] REG_SPARE_B = 3'd7;

    typedef longint vec3_t[3];

    typedef struct packed {
        logic signed [AXIS_W-1:0]  rx, ry, rz;
        logic signed [AXIS_W-1:0]  ux, uy, uz;
        logic signed [AXIS_W-1:0]  bx, by, bz;
        logic signed [SHIFT_W-1:0] su, sv, sn;
    } basis_t;

    typedef struct {
        logic [IN_W-1:0] x, y, z;
        bit              typed;
        basis_t          want;
    } probe_t;

    logic aclk;
    logic aresetn;
    logic cfg_wen;
    logic [REG_W-1:0] cfg_index;
    logic [IN_W-1:0] cfg_wdata;
    logic s_valid;
    logic s_ready;
    logic signed [IN_W-1:0] s_eye_x, s_eye_y, s_eye_z;
    logic m_valid;
    logic m_ready;
    logic signed [AXIS_W-1:0] m_right_x, m_right_y, m_right_z;
    logic signed [AXIS_W-1:0] m_upward_x, m_upward_y, m_upward_z;
    logic signed [AXIS_W-1:0] m_backward_x, m_backward_y, m_backward_z;
    logic signed [SHIFT_W-1:0] m_shift_u, m_shift_v, m_shift_n;

    logic signed [IN_W-1:0] tgt[3];
    logic signed [IN_W-1:0] upv[3];

    basis_t basis_q[$];
    probe_t probes[$];
    int     err_cnt;
    int     idle_cnt;
    int     hold_cnt;
    bit     hold_req;
    bit     gap_on;
    bit     stall_on;
    int     idle_pct;
    int     sent_cnt;
    int     got_cnt;
    int     zero_cnt;

    look_at_view_matrix_unit #(.FRAC_BITS(FRAC)) u_top (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_eye_x(s_eye_x), .s_eye_y(s_eye_y), .s_eye_z(s_eye_z),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_right_x(m_right_x), .m_right_y(m_right_y), .m_right_z(m_right_z),
        .m_upward_x(m_upward_x), .m_upward_y(m_upward_y), .m_upward_z(m_upward_z),
        .m_backward_x(m_backward_x), .m_backward_y(m_backward_y),
        .m_backward_z(m_backward_z),
        .m_shift_u(m_shift_u), .m_shift_v(m_shift_v), .m_shift_n(m_shift_n)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    function automatic longint unsigned int_sqrt(input longint unsigned x);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint round_q(input longint x);
        longint unsigned m, q;
        m = (x < 0) ? longint'(-x) : longint'(x);
        q = (m + (64'd1 << (FRAC - 1))) >> FRAC;
        return (x < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint sat(input longint x, input longint lim);
        if (x > lim) return lim;
        if (x < -lim) return -lim;
        return x;
    endfunction

    function automatic bit unit_vec(input vec3_t c, output vec3_t o);
        longint unsigned m[3];
        longint unsigned mx, s, r, num, q;
        int h;
        mx = 0;
        h = 0;
        for (int i = 0; i < 3; i++) begin
            o[i] = 0;
            m[i] = (c[i] < 0) ? longint'(-c[i]) : longint'(c[i]);
            if (m[i] > mx) mx = m[i];
        end
        while (mx >= (64'd1 << 30)) begin
            mx = mx >> 1;
            for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
        end
        s = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
        if (s == 0) return 1'b0;
        while (s < (64'd1 << 60)) begin
            s = s << 2;
            h++;
        end
        r = int_sqrt(s);
        for (int i = 0; i < 3; i++) begin
            num = m[i] << (FRAC + h);
            q = (num + r / 2) / r;
            o[i] = (c[i] < 0) ? -longint'(q) : longint'(q);
        end
        return 1'b1;
    endfunction

    function automatic basis_t predict_basis(input logic [IN_W-1:0] ex, ey, ez);
        vec3_t e, d, up, n, c, u;
        longint v[3];
        longint sh[3];
        longint one;
        basis_t b;
        one = 64'sd1 <<< FRAC;
        b = '0;
        e[0] = longint'($signed(ex));
        e[1] = longint'($signed(ey));
        e[2] = longint'($signed(ez));
        for (int i = 0; i < 3; i++) begin
            d[i] = e[i] - longint'(tgt[i]);
            up[i] = longint'(upv[i]);
        end
        if (!unit_vec(d, n)) return b;
        c[0] = up[1] * n[2] - up[2] * n[1];
        c[1] = up[2] * n[0] - up[0] * n[2];
        c[2] = up[0] * n[1] - up[1] * n[0];
        if (!unit_vec(c, u)) return b;
        v[0] = sat(round_q(n[1] * u[2] - n[2] * u[1]), one);
        v[1] = sat(round_q(n[2] * u[0] - n[0] * u[2]), one);
        v[2] = sat(round_q(n[0] * u[1] - n[1] * u[0]), one);
        sh[0] = sat(-round_q(u[0] * e[0] + u[1] * e[1] + u[2] * e[2]), SHIFT_LIM);
        sh[1] = sat(-round_q(v[0] * e[0] + v[1] * e[1] + v[2] * e[2]), SHIFT_LIM);
        sh[2] = sat(-round_q(n[0] * e[0] + n[1] * e[1] + n[2] * e[2]), SHIFT_LIM);
        b.rx = AXIS_W'(u[0]); b.ry = AXIS_W'(u[1]); b.rz = AXIS_W'(u[2]);
        b.ux = AXIS_W'(v[0]); b.uy = AXIS_W'(v[1]); b.uz = AXIS_W'(v[2]);
        b.bx = AXIS_W'(n[0]); b.by = AXIS_W'(n[1]); b.bz = AXIS_W'(n[2]);
        b.su = SHIFT_W'(sh[0]); b.sv = SHIFT_W'(sh[1]); b.sn = SHIFT_W'(sh[2]);
        return b;
    endfunction

    task automatic report_mismatch(input string name, input longint got, input longint want);
        err_cnt++;
        $display("mismatch on result %0d, %s: got %0d, want %0d", got_cnt, name, got, want);
    endtask

    task automatic check_field(input string name, input longint got, input longint want);
        if (got != want) report_mismatch(name, got, want);
    endtask

    task automatic write_reg(input logic [REG_W-1:0] idx, input logic [IN_W-1:0] val);
        cfg_wen <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        if (idx < 3) tgt[idx] = val;
        else if (idx < 6) upv[idx - 3] = val;
        @(negedge aclk);
        cfg_wen <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic send_eye(input logic [IN_W-1:0] ex, ey, ez, input bit typed,
                            input basis_t want);
        int ngap;
        ngap = 0;
        if (gap_on) begin
            while ($urandom_range(99) < idle_pct) ngap++;
        end
        if (ngap > 0) begin
            s_valid <= 1'b0;
            repeat (ngap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_eye_x <= ex;
        s_eye_y <= ey;
        s_eye_z <= ez;
        do @(posedge aclk); while (!s_ready);
        basis_q.push_back(typed ? want : predict_basis(ex, ey, ez));
        sent_cnt++;
        @(negedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (basis_q.size() != 0) @(negedge aclk);
    endtask

    task automatic add_probe(input logic [IN_W-1:0] x, y, z, input bit typed);
        probe_t p;
        p.x = x;
        p.y = y;
        p.z = z;
        p.typed = typed;
        p.want = '0;
        probes.push_back(p);
    endtask

    function automatic logic [IN_W-1:0] near(input logic [IN_W-1:0] base);
        int k;
        k = $urandom_range(23);
        return base + IN_W'(int'($urandom_range((1 << k) * 2)) - (1 << k));
    endfunction

    task automatic send_random();
        logic [IN_W-1:0] ex, ey, ez;
        int k;
        case ($urandom_range(9))
            0, 1, 2, 3: begin
                ex = IN_W'($urandom);
                ey = IN_W'($urandom);
                ez = IN_W'($urandom);
            end
            4, 5, 6: begin
                ex = near(tgt[0]);
                ey = near(tgt[1]);
                ez = near(tgt[2]);
            end
            7: begin
                ex = tgt[0];
                ey = tgt[1];
                ez = tgt[2];
            end
            8: begin
                k = int'($urandom_range(6)) - 3;
                ex = tgt[0] + IN_W'(k * upv[0]);
                ey = tgt[1] + IN_W'(k * upv[1]);
                ez = tgt[2] + IN_W'(k * upv[2]);
            end
            default: begin
                ex = IN_W'(int'($urandom_range(4000)) - 2000);
                ey = IN_W'(int'($urandom_range(4000)) - 2000);
                ez = IN_W'(int'($urandom_range(4000)) - 2000);
            end
        endcase
        send_eye(ex, ey, ez, 1'b0, '0);
    endtask

    task automatic random_config();
        for (int i = 0; i < 6; i++) begin
            case ($urandom_range(3))
                0: write_reg(REG_W'(i), IN_W'($urandom));
                1: write_reg(REG_W'(i), IN_W'(int'($urandom_range(131072)) - 65536));
                2: write_reg(REG_W'(i), '0);
                default: write_reg(REG_W'(i), IN_W'(int'($urandom_range(8)) - 4) << 16);
            endcase
        end
    endtask

    always @(negedge aclk) begin
        if (hold_req) begin
            hold_req = 1'b0;
            hold_cnt = HOLD_CYCLES;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= stall_on ? ($urandom_range(99) >= idle_pct) : 1'b1;
        end
    end

    always @(posedge aclk) begin
        basis_t w;
        if (aresetn && m_valid && m_ready) begin
            if (basis_q.size() == 0) begin
                err_cnt++;
                $display("unexpected result transfer %0d", got_cnt);
            end else begin
                w = basis_q.pop_front();
                check_field("right_x", m_right_x, w.rx);
                check_field("right_y", m_right_y, w.ry);
                check_field("right_z", m_right_z, w.rz);
                check_field("upward_x", m_upward_x, w.ux);
                check_field("upward_y", m_upward_y, w.uy);
                check_field("upward_z", m_upward_z, w.uz);
                check_field("backward_x", m_backward_x, w.bx);
                check_field("backward_y", m_backward_y, w.by);
                check_field("backward_z", m_backward_z, w.bz);
                check_field("shift_u", m_shift_u, w.su);
                check_field("shift_v", m_shift_v, w.sv);
                check_field("shift_n", m_shift_n, w.sn);
                if (w == '0) zero_cnt++;
            end
            got_cnt++;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cnt = 0;
        end else begin
            idle_cnt++;
        end
        if (idle_cnt >= IDLE_LIMIT) begin
            $display("timeout with %0d results outstanding", basis_q.size());
            $display("tb_top failed");
            $finish;
        end
    end

    initial begin
        aresetn = 1'b0;
        cfg_wen = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_valid = 1'b0;
        s_eye_x = '0;
        s_eye_y = '0;
        s_eye_z = '0;
        m_ready = 1'b0;
        err_cnt = 0;
        idle_cnt = 0;
        hold_cnt = 0;
        hold_req = 1'b0;
        gap_on = 1'b0;
        stall_on = 1'b0;
        idle_pct = 59;
        sent_cnt = 0;
        got_cnt = 0;
        zero_cnt = 0;
        tgt[0] = TARGET_X_RST;
        tgt[1] = TARGET_Y_RST;
        tgt[2] = TARGET_Z_RST;
        upv[0] = UPVEC_X_RST;
        upv[1] = UPVEC_Y_RST;
        upv[2] = UPVEC_Z_RST;

        add_probe(24'd1311, 24'd0, 24'd0, 1'b1);
        add_probe(24'd1311, 24'd65536, 24'd0, 1'b1);
        add_probe(24'd1311, 24'h800000, 24'd0, 1'b1);
        add_probe(24'd1311, 24'h7fffff, 24'd0, 1'b1);
        add_probe(24'd0, 24'd0, 24'd0, 1'b0);
        add_probe(24'h7fffff, 24'h7fffff, 24'h7fffff, 1'b0);
        add_probe(24'h800000, 24'h800000, 24'h800000, 1'b0);
        add_probe(24'h7fffff, 24'h800000, 24'h7fffff, 1'b0);
        add_probe(24'h800000, 24'h7fffff, 24'h800000, 1'b0);
        add_probe(24'd1311, 24'd0, 24'd65536, 1'b0);
        add_probe(24'd1311, 24'd0, 24'hffffff, 1'b0);
        add_probe(24'd1312, 24'd0, 24'd0, 1'b0);
        add_probe(24'd1310, 24'd1, 24'd0, 1'b0);
        add_probe(24'd100000, -24'd200000, 24'd300000, 1'b0);
        add_probe(24'hffffff, 24'hffffff, 24'hffffff, 1'b0);
        add_probe(24'h7fffff, 24'd0, 24'd0, 1'b0);
        add_probe(24'h7fffff, 24'h7fffff, 24'd0, 1'b0);

        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (probes[i]) send_eye(probes[i].x, probes[i].y, probes[i].z,
                                     probes[i].typed, probes[i].want);
        repeat (PHASE_ITEMS) send_random();
        drain();

        write_reg(REG_TARGET_X, 24'h7fffff);
        write_reg(REG_TARGET_Y, 24'h800000);
        write_reg(REG_TARGET_Z, 24'h7fffff);
        write_reg(REG_UPVEC_X, 24'h800000);
        write_reg(REG_UPVEC_Y, 24'h7fffff);
        write_reg(REG_UPVEC_Z, 24'h800000);
        write_reg(REG_SPARE_A, IN_W'($urandom));
        write_reg(REG_SPARE_B, IN_W'($urandom));
        gap_on = 1'b1;
        send_eye(24'h7fffff, 24'h800000, 24'h7fffff, 1'b1, '0);
        repeat (PHASE_ITEMS) send_random();
        drain();

        random_config();
        gap_on = 1'b0;
        stall_on = 1'b1;
        hold_req = 1'b1;
        repeat (PHASE_ITEMS) send_random();
        drain();

        random_config();
        write_reg(REG_UPVEC_X, '0);
        write_reg(REG_UPVEC_Y, '0);
        write_reg(REG_UPVEC_Z, '0);
        gap_on = 1'b1;
        idle_pct = 14;
        repeat (20) send_random();
        drain();

        random_config();
        repeat (PHASE_ITEMS) send_random();
        drain();

        write_reg(REG_TARGET_X, '0);
        write_reg(REG_TARGET_Y, '0);
        write_reg(REG_TARGET_Z, '0);
        write_reg(REG_UPVEC_X, 24'd0);
        write_reg(REG_UPVEC_Y, 24'd65536);
        write_reg(REG_UPVEC_Z, 24'd0);
        gap_on = 1'b0;
        stall_on = 1'b0;
        repeat (PHASE_ITEMS) send_random();
        drain();

        repeat (DRAIN_WAIT) @(posedge aclk);
        $display("covered %0d eye positions, %0d results checked, %0d degenerate",
                 sent_cnt, got_cnt, zero_cnt);
        $display("config sweeps: reset, extremes, null up, random; idle and stall mixes");
        if (err_cnt == 0 && basis_q.size() == 0) begin
            $display("tb_top passed");
        end else begin
            $display("%0d mismatches, %0d results missing", err_cnt, basis_q.size());
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
